// ===== hw/rtl/csvls_pkg.sv =====
// shared types and constants for the csv line field splitter
package csvls_pkg;

   // character codes
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_NUL   = 8'h00;

   // field counter and field limit width
   localparam int FIELD_W = 5;
   localparam logic [FIELD_W-1:0] FIELD_LIMIT_RESET = 5'd16;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      CLS_OTHER = 2'd0,
      CLS_QUOTE = 2'd1,
      CLS_COMMA = 2'd2,
      CLS_TERM  = 2'd3
   } char_class_type;

   typedef enum logic [1:0] {
      KIND_BYTE      = 2'd0,
      KIND_FIELD_END = 2'd1,
      KIND_LINE_END  = 2'd2,
      KIND_ERROR     = 2'd3
   } out_kind_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_TOO_MANY  = 2'd1,
      ERR_TOO_LONG  = 2'd2
   } error_code_type;

   // classified byte word carried through the queue
   typedef struct packed {
      logic [7:0]     data_byte;
      char_class_type cls;
   } class_word_type;

   // queue status seen by the producer and consumer
   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

endpackage

// ===== hw/rtl/csvls_front.sv =====
// front stage: accepts request bytes and classifies them
module csvls_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [7:0]               req_data_byte,
   input  csvls_pkg::queue_status_type q_status,
   output logic                     q_push,
   output csvls_pkg::class_word_type q_word
);

   logic                       valid_ff;
   logic                       valid_in;
   csvls_pkg::class_word_type  word_ff;
   csvls_pkg::class_word_type  word_in;
   logic                       load;

   always_comb begin
      word_in.data_byte = req_data_byte;
      unique case (req_data_byte)
         csvls_pkg::CH_QUOTE: word_in.cls = csvls_pkg::CLS_QUOTE;
         csvls_pkg::CH_COMMA: word_in.cls = csvls_pkg::CLS_COMMA;
         csvls_pkg::CH_LF,
         csvls_pkg::CH_CR,
         csvls_pkg::CH_NUL:   word_in.cls = csvls_pkg::CLS_TERM;
         default:             word_in.cls = csvls_pkg::CLS_OTHER;
      endcase
   end

   assign q_push    = valid_ff && !q_status.full;
   assign req_stall = valid_ff && q_status.full;
   assign load      = req_valid && !req_stall;
   assign valid_in  = load || (valid_ff && !q_push);
   assign q_word    = word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in;
      end
   end

endmodule

// ===== hw/rtl/csvls_queue.sv =====
// short queue between the front and back stages
module csvls_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  csvls_pkg::class_word_type     push_word,
   input  logic                          pop,
   output csvls_pkg::class_word_type     pop_word,
   output csvls_pkg::queue_status_type   status
);

   csvls_pkg::class_word_type             mem [csvls_pkg::QUEUE_DEPTH];
   logic [csvls_pkg::QPTR_W-1:0]          wr_ptr_ff;
   logic [csvls_pkg::QPTR_W-1:0]          wr_ptr_in;
   logic [csvls_pkg::QPTR_W-1:0]          rd_ptr_ff;
   logic [csvls_pkg::QPTR_W-1:0]          rd_ptr_in;
   logic [csvls_pkg::QCNT_W-1:0]          count_ff;
   logic [csvls_pkg::QCNT_W-1:0]          count_in;

   localparam logic [csvls_pkg::QCNT_W-1:0] DEPTH_CNT =
      csvls_pkg::QCNT_W'(csvls_pkg::QUEUE_DEPTH);
   localparam logic [csvls_pkg::QPTR_W-1:0] PTR_LAST =
      csvls_pkg::QPTR_W'(csvls_pkg::QUEUE_DEPTH - 1);

   assign status.full      = (count_ff == DEPTH_CNT);
   assign status.not_empty = (count_ff != '0);
   assign pop_word         = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_word;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      !(push && status.full))
      else $error("queue push while full");

   assert property (@(posedge clock) disable iff (reset)
      !(pop && !status.not_empty))
      else $error("queue pop while empty");

endmodule

// ===== hw/rtl/csvls_back.sv =====
// back stage: line parser state and registered result word
module csvls_back #(
   parameter int FIELD_CAP     = 16,
   parameter int MAX_FIELD_LEN = 256
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [csvls_pkg::FIELD_W-1:0]        field_limit,
   input  csvls_pkg::queue_status_type          q_status,
   input  csvls_pkg::class_word_type            q_word,
   output logic                                 q_pop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [1:0]                           rsp_out_kind,
   output logic [7:0]                           rsp_char_value,
   output logic [3:0]                           rsp_field_index,
   output logic [4:0]                           rsp_field_count,
   output logic [1:0]                           rsp_error_code
);

   localparam int FW    = csvls_pkg::FIELD_W;
   localparam int LEN_W = $clog2(MAX_FIELD_LEN);
   localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(MAX_FIELD_LEN - 1);
   localparam logic [FW-1:0] LIMIT_CAP =
      (FIELD_CAP > 31) ? FW'(31) : FW'(FIELD_CAP);

   logic              inq_ff, inq_in;
   logic              pend_ff, pend_in;
   logic              drop_ff, drop_in;
   logic [FW-1:0]     field_ff, field_in;
   logic [LEN_W-1:0]  len_ff, len_in;

   logic              out_valid_ff, out_valid_in;
   csvls_pkg::out_kind_type   kind_ff, kind_in;
   logic [7:0]                char_ff, char_in;
   logic [3:0]                idx_ff, idx_in;
   logic [4:0]                count_ff, count_in;
   csvls_pkg::error_code_type err_ff, err_in;

   logic [FW-1:0]     limit;
   logic              take;

   assign limit = (field_limit > LIMIT_CAP) ? LIMIT_CAP : field_limit;
   assign q_pop = q_status.not_empty && (!out_valid_ff || !rsp_stall);

   always_comb begin
      logic          done;
      logic          emit;
      logic          do_fail;
      logic          do_add;
      logic [7:0]    add_val;
      csvls_pkg::error_code_type fail_code;
      logic          is_lf;

      done      = 1'b0;
      emit      = 1'b0;
      do_fail   = 1'b0;
      do_add    = 1'b0;
      add_val   = q_word.data_byte;
      fail_code = csvls_pkg::ERR_NONE;
      is_lf     = (q_word.data_byte == csvls_pkg::CH_LF);

      inq_in   = inq_ff;
      pend_in  = pend_ff;
      drop_in  = drop_ff;
      field_in = field_ff;
      len_in   = len_ff;

      kind_in  = csvls_pkg::KIND_BYTE;
      char_in  = 8'd0;
      idx_in   = field_ff[3:0];
      count_in = 5'd0;
      err_in   = csvls_pkg::ERR_NONE;

      if (q_pop) begin
         if (drop_ff) begin
            // skipping the rest of a bad or cr/nul-ended line
            if (is_lf) begin
               drop_in = 1'b0;
            end
         end else if (field_ff >= limit) begin
            do_fail   = 1'b1;
            fail_code = csvls_pkg::ERR_TOO_MANY;
         end else begin
            if (pend_ff) begin
               pend_in = 1'b0;
               if (q_word.cls == csvls_pkg::CLS_QUOTE) begin
                  // doubled quote is a literal quote
                  do_add  = 1'b1;
                  add_val = csvls_pkg::CH_QUOTE;
                  done    = 1'b1;
               end else begin
                  inq_in = 1'b0;
               end
            end
            if (!done) begin
               if (q_word.cls == csvls_pkg::CLS_TERM) begin
                  emit     = 1'b1;
                  kind_in  = csvls_pkg::KIND_LINE_END;
                  count_in = 5'(field_ff + 1'b1);
                  inq_in   = 1'b0;
                  pend_in  = 1'b0;
                  field_in = '0;
                  len_in   = '0;
                  drop_in  = !is_lf;
               end else if (inq_ff && pend_in == 1'b0 && inq_in) begin
                  if (q_word.cls == csvls_pkg::CLS_QUOTE) begin
                     pend_in = 1'b1;
                  end else begin
                     do_add = 1'b1;
                  end
               end else if (q_word.cls == csvls_pkg::CLS_QUOTE) begin
                  inq_in = 1'b1;
               end else if (q_word.cls == csvls_pkg::CLS_COMMA) begin
                  if ({1'b0, field_ff} + 1'b1 >= {1'b0, limit}) begin
                     do_fail   = 1'b1;
                     fail_code = csvls_pkg::ERR_TOO_MANY;
                  end else begin
                     emit     = 1'b1;
                     kind_in  = csvls_pkg::KIND_FIELD_END;
                     field_in = field_ff + 1'b1;
                     len_in   = '0;
                  end
               end else begin
                  do_add = 1'b1;
               end
            end
            if (do_add) begin
               if (len_ff >= LEN_LAST) begin
                  do_fail   = 1'b1;
                  fail_code = csvls_pkg::ERR_TOO_LONG;
               end else begin
                  emit    = 1'b1;
                  kind_in = csvls_pkg::KIND_BYTE;
                  char_in = add_val;
                  len_in  = len_ff + 1'b1;
               end
            end
         end
         if (do_fail) begin
            emit     = 1'b1;
            kind_in  = csvls_pkg::KIND_ERROR;
            char_in  = 8'd0;
            count_in = 5'd0;
            err_in   = fail_code;
            inq_in   = 1'b0;
            pend_in  = 1'b0;
            field_in = '0;
            len_in   = '0;
            drop_in  = !is_lf;
         end
      end

      take = emit;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_stall) begin
         out_valid_in = out_valid_ff;
      end else begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inq_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         drop_ff      <= 1'b0;
         field_ff     <= '0;
         len_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         inq_ff       <= inq_in;
         pend_ff      <= pend_in;
         drop_ff      <= drop_in;
         field_ff     <= field_in;
         len_ff       <= len_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         kind_ff  <= kind_in;
         char_ff  <= char_in;
         idx_ff   <= idx_in;
         count_ff <= count_in;
         err_ff   <= err_in;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_kind    = kind_ff;
   assign rsp_char_value  = char_ff;
   assign rsp_field_index = idx_ff;
   assign rsp_field_count = count_ff;
   assign rsp_error_code  = err_ff;

   assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> inq_ff)
      else $error("quote pending outside quoted section");

   assert property (@(posedge clock) disable iff (reset)
      drop_ff |-> (field_ff == '0 && !inq_ff && len_ff == '0))
      else $error("line state not cleared while dropping");

   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ((kind_ff == csvls_pkg::KIND_ERROR) ==
                        (err_ff != csvls_pkg::ERR_NONE)))
      else $error("error code does not match result kind");

   assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |=> out_valid_ff)
      else $error("stalled result word lost");

endmodule

// ===== hw/rtl/csv_line_field_splitter.sv =====
// top level of the csv line field splitter: front, queue, back, csr
// an accepted byte passes the front register and the queue; its word is registered in the back stage
// throughput: one byte per cycle unless either side stalls; back parser state updates for each byte popped
// a four-word queue lets the request side keep flowing while the result side stalls
// reset is synchronous and active high; it clears the line state, the queue and the
// output valid, and sets field_limit to 16; no clearing pass is needed
module csv_line_field_splitter #(
   parameter int FIELD_CAP     = 16,
   parameter int MAX_FIELD_LEN = 256
) (
   input  logic       clock,
   input  logic       reset,
   // request byte channel
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   // result word channel
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_out_kind,
   output logic [7:0] rsp_char_value,
   output logic [3:0] rsp_field_index,
   output logic [4:0] rsp_field_count,
   output logic [1:0] rsp_error_code,
   // field_limit register write
   input  logic       csr_wr_en,
   input  logic [4:0] csr_wr_data
);

   // field limit register; the user writes it only while the block is idle, the block does not enforce it
   logic [csvls_pkg::FIELD_W-1:0] field_limit_ff;
   logic [csvls_pkg::FIELD_W-1:0] field_limit_in;

   // front to queue
   logic                        q_push;
   csvls_pkg::class_word_type   q_push_word;
   // queue to back
   logic                        q_pop;
   csvls_pkg::class_word_type   q_pop_word;
   csvls_pkg::queue_status_type q_status;

   assign field_limit_in = csr_wr_en ? csr_wr_data : field_limit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         field_limit_ff <= csvls_pkg::FIELD_LIMIT_RESET;
      end else begin
         field_limit_ff <= field_limit_in;
      end
   end

   // front: registers each accepted byte with its character class
   csvls_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .q_status      (q_status),
      .q_push        (q_push),
      .q_word        (q_push_word)
   );

   // queue: decouples the front from a stalled result side
   csvls_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word (q_push_word),
      .pop       (q_pop),
      .pop_word  (q_pop_word),
      .status    (q_status)
   );

   // back: quote / field / line state and the registered result word
   csvls_back #(
      .FIELD_CAP     (FIELD_CAP),
      .MAX_FIELD_LEN (MAX_FIELD_LEN)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .field_limit     (field_limit_ff),
      .q_status        (q_status),
      .q_word          (q_pop_word),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_kind    (rsp_out_kind),
      .rsp_char_value  (rsp_char_value),
      .rsp_field_index (rsp_field_index),
      .rsp_field_count (rsp_field_count),
      .rsp_error_code  (rsp_error_code)
   );

endmodule

// ===== test/csv_line_field_splitter_tb.sv =====
// testbench for the csv line field splitter: directed and random byte streams checked against a built-in parser model
module csv_line_field_splitter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FIELD_CAP     = 16;
   localparam int MAX_FIELD_LEN = 256;
   // drain wait: covers the front, queue and back registers behind a byte; a little margin on top
   localparam int DRAIN_CYCLES  = 6;

   // every input starts at a known value
   logic       clock         = 1'b0;
   logic       reset         = 1'b1;
   logic       req_valid     = 1'b0;
   logic [7:0] req_data_byte = 8'h00;
   logic       rsp_stall     = 1'b0;
   logic       csr_wr_en     = 1'b0;
   logic [4:0] csr_wr_data   = 5'd0;
   logic       req_stall;
   logic       rsp_valid;
   logic [1:0] rsp_out_kind;
   logic [7:0] rsp_char_value;
   logic [3:0] rsp_field_index;
   logic [4:0] rsp_field_count;
   logic [1:0] rsp_error_code;

   always #2 clock = ~clock;

   csv_line_field_splitter #(
      .FIELD_CAP    (FIELD_CAP),
      .MAX_FIELD_LEN(MAX_FIELD_LEN)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_byte  (req_data_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_kind   (rsp_out_kind),
      .rsp_char_value (rsp_char_value),
      .rsp_field_index(rsp_field_index),
      .rsp_field_count(rsp_field_count),
      .rsp_error_code (rsp_error_code),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   // one expected result word
   typedef struct {
      csvls_pkg::out_kind_type   kind;
      logic [7:0]                ch;
      logic [3:0]                idx;
      logic [4:0]                cnt;
      csvls_pkg::error_code_type err;
   } split_word_type;

   split_word_type expected_words[$];

   // parser state mirrored by the testbench
   logic [4:0] fields_cfg = csvls_pkg::FIELD_LIMIT_RESET;
   bit         quoted     = 1'b0;
   bit         quote_held = 1'b0;
   bit         skip_to_lf = 1'b0;
   int         field_no   = 0;
   int         field_len  = 0;

   int mismatch_count = 0;
   int bytes_sent     = 0;
   // no random idling on either side while set
   bit quiet          = 1'b0;
   // cycles left in a forced receiver hold-off
   int hold_left      = 0;

   // ---------------------------------------------------------------
   // parser model
   // ---------------------------------------------------------------

   function automatic void push_word(input csvls_pkg::out_kind_type k, input logic [7:0] ch,
                                     input int idx, input int cnt,
                                     input csvls_pkg::error_code_type e);
      split_word_type w;
      w.kind = k;
      w.ch   = ch;
      w.idx  = 4'(idx);
      w.cnt  = 5'(cnt);
      w.err  = e;
      expected_words.push_back(w);
   endfunction

   function automatic void restart_line();
      quoted     = 1'b0;
      quote_held = 1'b0;
      field_no   = 0;
      field_len  = 0;
   endfunction

   // error word; the rest of the line is dropped unless the byte was the newline itself
   function automatic void line_error(input logic [7:0] c, input csvls_pkg::error_code_type e);
      int idx;
      idx = field_no;
      restart_line();
      skip_to_lf = (c != csvls_pkg::CH_LF);
      push_word(csvls_pkg::KIND_ERROR, 8'h00, idx, 0, e);
   endfunction

   function automatic void take_byte(input logic [7:0] c);
      if (field_len + 1 >= MAX_FIELD_LEN) begin
         line_error(c, csvls_pkg::ERR_TOO_LONG);
      end else begin
         field_len++;
         push_word(csvls_pkg::KIND_BYTE, c, field_no, 0, csvls_pkg::ERR_NONE);
      end
   endfunction

   function automatic void split_byte(input logic [7:0] c);
      int lim;
      int idx;
      lim = (fields_cfg > FIELD_CAP) ? FIELD_CAP : int'(fields_cfg);
      if (skip_to_lf) begin
         if (c == csvls_pkg::CH_LF) skip_to_lf = 1'b0;
         return;
      end
      // also catches a zero limit or one lowered below the open field
      if (field_no >= lim) begin
         line_error(c, csvls_pkg::ERR_TOO_MANY);
         return;
      end
      // closing quote or first half of a doubled quote
      if (quote_held) begin
         quote_held = 1'b0;
         if (c == csvls_pkg::CH_QUOTE) begin
            take_byte(c);
            return;
         end
         quoted = 1'b0;
      end
      if (c == csvls_pkg::CH_LF || c == csvls_pkg::CH_CR || c == csvls_pkg::CH_NUL) begin
         idx = field_no;
         restart_line();
         skip_to_lf = (c != csvls_pkg::CH_LF);
         push_word(csvls_pkg::KIND_LINE_END, 8'h00, idx, idx + 1, csvls_pkg::ERR_NONE);
         return;
      end
      if (quoted) begin
         if (c == csvls_pkg::CH_QUOTE) quote_held = 1'b1;
         else take_byte(c);
         return;
      end
      if (c == csvls_pkg::CH_QUOTE) begin
         quoted = 1'b1;
         return;
      end
      if (c == csvls_pkg::CH_COMMA) begin
         if (field_no + 1 >= lim) begin
            line_error(c, csvls_pkg::ERR_TOO_MANY);
         end else begin
            push_word(csvls_pkg::KIND_FIELD_END, 8'h00, field_no, 0, csvls_pkg::ERR_NONE);
            field_no++;
            field_len = 0;
         end
         return;
      end
      take_byte(c);
   endfunction

   // ---------------------------------------------------------------
   // reporting and checking
   // ---------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      // keep the log short if the block is badly broken
      if (mismatch_count < 50) $display("%0t ns mismatch: %s", $time, msg);
      mismatch_count++;
   endtask

   task automatic compare_field(input string name, input logic [7:0] got,
                                input logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   // each word taken from the block is held against the oldest expectation
   always @(posedge clock) begin : check_words
      split_word_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word kind %0d index %0d",
                                      rsp_out_kind, rsp_field_index));
         end else begin
            want = expected_words.pop_front();
            compare_field("out_kind", 8'(rsp_out_kind), 8'(want.kind));
            compare_field("char_value", rsp_char_value, want.ch);
            compare_field("field_index", 8'(rsp_field_index), 8'(want.idx));
            compare_field("fields_in_line", 8'(rsp_field_count), 8'(want.cnt));
            compare_field("error_code", 8'(rsp_error_code), 8'(want.err));
         end
      end
   end

   // ---------------------------------------------------------------
   // receiver side
   // ---------------------------------------------------------------

   // hold-off counter, runs on its own
   always @(posedge clock) begin
      if (hold_left > 0) hold_left <= hold_left - 1;
   end

   // random stalls, none in quiet stretches, solid during a hold-off
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
      end else if (quiet) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < 12);
      end
   end

   // ---------------------------------------------------------------
   // sender side
   // ---------------------------------------------------------------

   // offer one byte, wait for the handshake, then predict its word
   // valid stays high afterwards so back-to-back bytes need no drop
   task automatic send_byte(input logic [7:0] b);
      if (!quiet && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      do @(posedge clock); while (req_stall !== 1'b0);
      split_byte(b);
      bytes_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
   endtask

   // any byte that has no meaning to the parser
   function automatic logic [7:0] plain_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(255));
      while (b == csvls_pkg::CH_QUOTE || b == csvls_pkg::CH_COMMA || b == csvls_pkg::CH_LF ||
             b == csvls_pkg::CH_CR || b == csvls_pkg::CH_NUL);
      return b;
   endfunction

   // only while the block is idle: all words back, then the pipeline drained
   task automatic write_field_limit(input logic [4:0] value);
      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en  <= 1'b0;
      fields_cfg = value;
   endtask

   // well-formed line with random content; one field too many or an overlong field now and then
   task automatic send_random_line(input int lim);
      int nf;
      int len;
      int r;
      nf = $urandom_range(lim + 1, 1);
      for (int f = 0; f < nf; f++) begin
         if (f > 0) send_byte(csvls_pkg::CH_COMMA);
         len = ($urandom_range(59) == 0) ? $urandom_range(270, 240) : $urandom_range(5);
         if ($urandom_range(2) == 0) begin
            send_byte(csvls_pkg::CH_QUOTE);
            for (int k = 0; k < len; k++) begin
               r = $urandom_range(9);
               if (r == 0) begin
                  // doubled quote gives a literal quote
                  send_byte(csvls_pkg::CH_QUOTE);
                  send_byte(csvls_pkg::CH_QUOTE);
               end else if (r == 1) begin
                  send_byte(csvls_pkg::CH_COMMA);
               end else begin
                  send_byte(plain_byte());
               end
            end
            send_byte(csvls_pkg::CH_QUOTE);
            // byte right after a closing quote
            if ($urandom_range(4) == 0) send_byte(plain_byte());
         end else begin
            for (int k = 0; k < len; k++) send_byte(plain_byte());
         end
      end
      r = $urandom_range(9);
      if (r <= 6) begin
         send_byte(csvls_pkg::CH_LF);
      end else if (r == 9) begin
         send_byte(csvls_pkg::CH_CR);
         send_byte(csvls_pkg::CH_LF);
      end else begin
         // cr or nul, then junk that gets dropped up to the newline
         send_byte(r == 7 ? csvls_pkg::CH_CR : csvls_pkg::CH_NUL);
         repeat ($urandom_range(3)) send_byte(plain_byte());
         send_byte(csvls_pkg::CH_LF);
      end
   endtask

   // raw bytes, biased toward the characters the parser reacts to
   task automatic send_noise(input int n);
      logic [7:0] b;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(9) < 3) begin
            case ($urandom_range(4))
               0:       b = csvls_pkg::CH_QUOTE;
               1:       b = csvls_pkg::CH_COMMA;
               2:       b = csvls_pkg::CH_LF;
               3:       b = csvls_pkg::CH_CR;
               default: b = csvls_pkg::CH_NUL;
            endcase
         end else begin
            b = 8'($urandom_range(255));
         end
         send_byte(b);
      end
   endtask

   // ---------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------

   // plain fields, an empty line, extreme byte values, nul ending with dropped tail
   task automatic test_plain_lines();
      send_text("ab,c\n");
      send_byte(csvls_pkg::CH_LF);
      send_byte(8'hFF);
      send_byte(8'h01);
      send_byte(8'h80);
      send_byte(csvls_pkg::CH_NUL);
      send_text("z\n");
   endtask

   // quoted sections: doubled quote, pending quote at cr, newline inside quotes,
   // other byte right after a closing quote
   task automatic test_quoted_fields();
      send_text("\"a\"\"\"\r");
      send_text("x\n");
      send_text("\"q,\n");
      send_text("\"b\"c\n");
   endtask

   task automatic test_field_limit();
      // comma that would open field number field_limit
      write_field_limit(5'd1);
      send_text("a,b\n");
      // zero limit: error on the first byte, and on a newline no dropping follows
      write_field_limit(5'd0);
      send_text("x\n");
      send_byte(csvls_pkg::CH_LF);
      // above the top it acts as sixteen: 16 fields pass, one more comma fails
      write_field_limit(5'd31);
      send_text(",,,,,,,,,,,,,,,,\n");
      // limit lowered mid-line below the open field
      write_field_limit(5'd16);
      send_text("a,b,c");
      write_field_limit(5'd2);
      send_text("d\n");
      write_field_limit(5'd16);
   endtask

   // longest legal field, then one that runs over inside quotes
   task automatic test_long_fields();
      repeat (MAX_FIELD_LEN - 1) send_byte(plain_byte());
      send_byte(csvls_pkg::CH_LF);
      send_byte(csvls_pkg::CH_QUOTE);
      repeat (MAX_FIELD_LEN + 2) send_byte(plain_byte());
      send_byte(csvls_pkg::CH_LF);
   endtask

   // receiver holds off while the sender keeps offering, so the block backs up
   task automatic test_backpressure();
      int start;
      quiet     <= 1'b1;
      hold_left <= 80;
      start = bytes_sent;
      while (bytes_sent - start < 40) send_random_line(FIELD_CAP);
      quiet <= 1'b0;
   endtask

   task automatic test_random_traffic(input logic [4:0] limit_value, input int byte_budget,
                                      input bit no_idle);
      int start;
      int lim;
      write_field_limit(limit_value);
      lim = (limit_value > FIELD_CAP) ? FIELD_CAP : int'(limit_value);
      if (no_idle) quiet <= 1'b1;
      start = bytes_sent;
      while (bytes_sent - start < byte_budget) begin
         if ($urandom_range(9) == 0) send_noise($urandom_range(6, 1));
         else send_random_line(lim);
      end
      quiet <= 1'b0;
   endtask

   // ---------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_plain_lines();
      test_quoted_fields();
      test_field_limit();
      test_long_fields();
      test_backpressure();
      test_random_traffic(5'd16, 100, 1'b0);
      test_random_traffic(5'($urandom_range(16, 1)), 100, 1'b0);
      // long stretch with no idling anywhere
      test_random_traffic(5'd31, 200, 1'b1);
      test_random_traffic(5'd3, 100, 1'b0);
      test_random_traffic(5'd1, 100, 1'b0);

      // wait for the last words, bounded, then let the pipeline settle
      req_valid <= 1'b0;
      for (int w = 0; w < 5000 && expected_words.size() != 0; w++) @(posedge clock);
      repeat (DRAIN_CYCLES * 2) @(posedge clock);
      if (expected_words.size() != 0)
         report_mismatch($sformatf("%0d expected words never arrived", expected_words.size()));

      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule
